// ----- sv/cbc_pkg.sv -----
// Package: shared types, constants and tables of the cartridge bank controller.
package cbc_pkg;

  localparam int ROM_BANKS    = 32;
  localparam int RAM_BANK_NUM = 4;
  localparam int ROM_BANK_W   = 5;
  localparam int ROM_OFS_W    = 14;
  localparam int RAM_OFS_W    = 13;
  localparam int ROM_AW       = ROM_BANK_W + ROM_OFS_W;
  localparam int RAM_DEPTH    = RAM_BANK_NUM * (1 << RAM_OFS_W);
  localparam int RAM_AW       = $clog2(RAM_DEPTH);
  localparam int RAM_BANK_W   = 2;

  localparam logic [1:0] FUNC_READ  = 2'd0;
  localparam logic [1:0] FUNC_WRITE = 2'd1;
  localparam logic [1:0] FUNC_LOAD  = 2'd2;

  localparam logic CFG_CART_TYPE = 1'b0;
  localparam logic CFG_RAM_CODE  = 1'b1;

  localparam logic [7:0] CART_MBC      = 8'd1;
  localparam logic [7:0] CART_MBC_RAM  = 8'd2;
  localparam logic [7:0] CART_MBC_BATT = 8'd3;

  localparam logic [7:0] RAM_CODE_ONE   = 8'd2;
  localparam logic [7:0] RAM_CODE_FOUR  = 8'd3;
  localparam logic [7:0] RAM_CODE_ALL   = 8'd4;
  localparam logic [7:0] RAM_CODE_EIGHT = 8'd5;

  localparam logic [2:0] REGION_RAM_EN   = 3'd0;
  localparam logic [2:0] REGION_ROM_BANK = 3'd1;
  localparam logic [2:0] REGION_RAM_SEL  = 3'd2;
  localparam logic [2:0] REGION_MODE     = 3'd3;
  localparam logic [2:0] REGION_CART_RAM = 3'd5;

  localparam logic [3:0] RAM_EN_KEY = 4'hA;

  typedef enum logic [1:0] {
    SEL_ZERO = 2'd0,
    SEL_ROM  = 2'd1,
    SEL_RAM  = 2'd2,
    SEL_FF   = 2'd3
  } rd_sel_t;

  typedef struct packed {
    logic [1:0]        func;
    logic [15:0]       address;
    logic [ROM_AW-1:0] rom_offset;
    logic [7:0]        data;
  } in_word_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       save_pending;
  } out_word_t;

  typedef struct packed {
    logic              rom_we;
    logic [ROM_AW-1:0] rom_addr;
    logic              ram_we;
    logic [RAM_AW-1:0] ram_addr;
    logic [7:0]        wdata;
  } mem_req_t;

  typedef logic [(1 << ROM_BANK_W)-1:0][ROM_BANK_W-1:0] bank_wrap_t;

  function automatic bank_wrap_t bank_wrap_table();
    bank_wrap_t            t;
    logic [ROM_BANK_W-1:0] w;
    w = '0;
    for (int i = 0; i < (1 << ROM_BANK_W); i++) begin
      t[i] = w;
      if (w == ROM_BANK_W'(ROM_BANKS - 1)) begin
        w = '0;
      end else begin
        w = w + ROM_BANK_W'(1);
      end
    end
    return t;
  endfunction

  localparam bank_wrap_t ROM_BANK_WRAP = bank_wrap_table();

endpackage

// ----- sv/cartridge_bank_controller.sv -----
// Top level: bank registers, bus decode and result word of the cartridge controller.
// The result word appears in the cycle after start is taken, for one cycle.
// Throughput: one item per cycle while busy is low; ROM and RAM are single-port synchronous memories.
// Reset: registers return to their reset values and RAM is swept to zero,
// one byte a cycle, over all RAM_DEPTH (32768) bytes with busy high.
// The receiver cannot stall; config is taken at any cycle with cfg_we high.
module cartridge_bank_controller (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  cbc_pkg::in_word_t in_word,
  output logic              out_valid,
  output cbc_pkg::out_word_t out_word,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [7:0]        cfg_data
);

  logic                                  cart_type_r;
  logic [7:0]                            cart_code_r;
  logic [7:0]                            ram_code_r;
  logic                                  ram_enable_r, ram_enable_nxt;
  logic [cbc_pkg::ROM_BANK_W-1:0]        rom_bank_r, rom_bank_nxt;
  logic [cbc_pkg::RAM_BANK_W-1:0]        ram_sel_r, ram_sel_nxt;
  logic [cbc_pkg::RAM_BANK_W-1:0]        active_bank_r, active_bank_nxt;
  logic                                  mode_r, mode_nxt;
  logic                                  save_r, save_nxt;
  logic                                  out_valid_r;
  cbc_pkg::rd_sel_t                      sel_r, sel_nxt;

  cbc_pkg::mem_req_t req;
  logic [7:0]        rom_q;
  logic [7:0]        ram_q;
  logic              clearing;
  logic              accept;
  logic              banking;
  logic              bank_present;
  logic [2:0]        region;
  logic [cbc_pkg::ROM_BANK_W-1:0] wrap_bank;

  cbc_store u_store (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (req),
    .rom_q    (rom_q),
    .ram_q    (ram_q),
    .clearing (clearing)
  );

  assign busy   = clearing;
  assign accept = start & ~clearing;
  assign region = in_word.address[15:13];

  always_comb begin
    banking   = (cart_code_r == cbc_pkg::CART_MBC) || (cart_code_r == cbc_pkg::CART_MBC_RAM) ||
                (cart_code_r == cbc_pkg::CART_MBC_BATT);
    wrap_bank = cbc_pkg::ROM_BANK_WRAP[rom_bank_r];
    case (ram_code_r)
      cbc_pkg::RAM_CODE_ONE:   bank_present = (active_bank_r == '0);
      cbc_pkg::RAM_CODE_FOUR:  bank_present = 1'b1;
      cbc_pkg::RAM_CODE_ALL:   bank_present = 1'b1;
      cbc_pkg::RAM_CODE_EIGHT: bank_present = 1'b1;
      default:                 bank_present = 1'b0;
    endcase
    bank_present = bank_present && (32'(active_bank_r) < cbc_pkg::RAM_BANK_NUM);
  end

  always_comb begin
    ram_enable_nxt  = ram_enable_r;
    rom_bank_nxt    = rom_bank_r;
    ram_sel_nxt     = ram_sel_r;
    active_bank_nxt = active_bank_r;
    mode_nxt        = mode_r;
    save_nxt        = save_r;
    sel_nxt         = cbc_pkg::SEL_ZERO;
    req.rom_we      = 1'b0;
    req.rom_addr    = {{cbc_pkg::ROM_BANK_W{1'b0}}, in_word.address[cbc_pkg::ROM_OFS_W-1:0]};
    req.ram_we      = 1'b0;
    req.ram_addr    = cbc_pkg::RAM_AW'({active_bank_r,
                                        in_word.address[cbc_pkg::RAM_OFS_W-1:0]});
    req.wdata       = in_word.data;
    if (accept) begin
      case (in_word.func)
        cbc_pkg::FUNC_READ: begin
          case (region)
            cbc_pkg::REGION_RAM_EN, cbc_pkg::REGION_ROM_BANK: begin
              sel_nxt = cbc_pkg::SEL_ROM;
            end
            cbc_pkg::REGION_RAM_SEL, cbc_pkg::REGION_MODE: begin
              req.rom_addr = {wrap_bank, in_word.address[cbc_pkg::ROM_OFS_W-1:0]};
              sel_nxt      = banking ? cbc_pkg::SEL_ROM : cbc_pkg::SEL_FF;
            end
            cbc_pkg::REGION_CART_RAM: begin
              sel_nxt = (banking && ram_enable_r && bank_present) ? cbc_pkg::SEL_RAM :
                                                                    cbc_pkg::SEL_FF;
            end
            default: begin
              sel_nxt = cbc_pkg::SEL_FF;
            end
          endcase
        end
        cbc_pkg::FUNC_WRITE: begin
          if (banking) begin
            case (region)
              cbc_pkg::REGION_RAM_EN: begin
                ram_enable_nxt = (in_word.data[3:0] == cbc_pkg::RAM_EN_KEY);
              end
              cbc_pkg::REGION_ROM_BANK: begin
                rom_bank_nxt = (in_word.data[4:0] == '0) ? cbc_pkg::ROM_BANK_W'(1) :
                                                           in_word.data[4:0];
              end
              cbc_pkg::REGION_RAM_SEL: begin
                ram_sel_nxt = in_word.data[1:0];
                if (mode_r) begin
                  active_bank_nxt = in_word.data[1:0];
                end
              end
              cbc_pkg::REGION_MODE: begin
                mode_nxt = in_word.data[0];
                if (in_word.data[0]) begin
                  active_bank_nxt = ram_sel_r;
                end
              end
              cbc_pkg::REGION_CART_RAM: begin
                if (ram_enable_r && bank_present) begin
                  req.ram_we = 1'b1;
                  if (cart_code_r == cbc_pkg::CART_MBC_BATT) begin
                    save_nxt = 1'b1;
                  end
                end
              end
              default: begin
              end
            endcase
          end
        end
        cbc_pkg::FUNC_LOAD: begin
          req.rom_we   = 1'b1;
          req.rom_addr = in_word.rom_offset;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cart_type_r   <= 1'b0;
      cart_code_r   <= '0;
      ram_code_r    <= '0;
      ram_enable_r  <= 1'b0;
      rom_bank_r    <= cbc_pkg::ROM_BANK_W'(1);
      ram_sel_r     <= '0;
      active_bank_r <= '0;
      mode_r        <= 1'b0;
      save_r        <= 1'b0;
      out_valid_r   <= 1'b0;
      sel_r         <= cbc_pkg::SEL_ZERO;
    end else begin
      if (cfg_we && cfg_index == cbc_pkg::CFG_CART_TYPE) begin
        cart_code_r <= cfg_data;
        cart_type_r <= 1'b1;
      end
      if (cfg_we && cfg_index == cbc_pkg::CFG_RAM_CODE) begin
        ram_code_r <= cfg_data;
      end
      ram_enable_r  <= ram_enable_nxt;
      rom_bank_r    <= rom_bank_nxt;
      ram_sel_r     <= ram_sel_nxt;
      active_bank_r <= active_bank_nxt;
      mode_r        <= mode_nxt;
      save_r        <= save_nxt;
      out_valid_r   <= accept;
      sel_r         <= sel_nxt;
    end
  end

  always_comb begin
    case (sel_r)
      cbc_pkg::SEL_ROM: out_word.read_data = rom_q;
      cbc_pkg::SEL_RAM: out_word.read_data = ram_q;
      cbc_pkg::SEL_FF:  out_word.read_data = 8'hFF;
      default:          out_word.read_data = 8'h00;
    endcase
    out_word.save_pending = save_r;
  end

  assign out_valid = out_valid_r;

`ifndef ASSERT_OFF
  a_no_word_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
    busy |=> !out_valid) else $error("result word after an item taken during clear");

  a_word_follows_start: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> out_valid) else $error("accepted item gave no result word");

  a_save_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    save_r |=> save_r) else $error("save pending flag dropped");

  a_rom_bank_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    rom_bank_r != '0) else $error("ROM bank register holds zero");

  a_save_needs_battery: assert property (@(posedge clk) disable iff (!rst_n)
    (!save_r && save_nxt) |-> (cart_type_r && cart_code_r == cbc_pkg::CART_MBC_BATT))
    else $error("save flag raised on a cart without battery");
`endif

endmodule

// ----- sv/cbc_store.sv -----
// ROM and cartridge RAM storage with the RAM clear sweep after reset.
module cbc_store (
  input  logic              clk,
  input  logic              rst_n,
  input  cbc_pkg::mem_req_t req,
  output logic [7:0]        rom_q,
  output logic [7:0]        ram_q,
  output logic              clearing
);

  logic [7:0] rom_mem [cbc_pkg::ROM_BANKS * (1 << cbc_pkg::ROM_OFS_W)];
  logic [7:0] ram_mem [cbc_pkg::RAM_DEPTH];

  logic [7:0]                rom_q_r;
  logic [7:0]                ram_q_r;
  logic                      clearing_r;
  logic [cbc_pkg::RAM_AW-1:0] clr_cnt_r;

  logic                       ram_we;
  logic [cbc_pkg::RAM_AW-1:0] ram_addr;
  logic [7:0]                 ram_wdata;

  always_comb begin
    ram_we    = clearing_r | req.ram_we;
    ram_addr  = clearing_r ? clr_cnt_r : req.ram_addr;
    ram_wdata = clearing_r ? 8'h00 : req.wdata;
  end

  always_ff @(posedge clk) begin
    if (req.rom_we) begin
      rom_mem[req.rom_addr] <= req.wdata;
    end
    rom_q_r <= rom_mem[req.rom_addr];
  end

  always_ff @(posedge clk) begin
    if (ram_we) begin
      ram_mem[ram_addr] <= ram_wdata;
    end
    ram_q_r <= ram_mem[ram_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r <= 1'b1;
      clr_cnt_r  <= '0;
    end else if (clearing_r) begin
      clr_cnt_r <= clr_cnt_r + cbc_pkg::RAM_AW'(1);
      if (clr_cnt_r == cbc_pkg::RAM_AW'(cbc_pkg::RAM_DEPTH - 1)) begin
        clearing_r <= 1'b0;
      end
    end
  end

  assign rom_q    = rom_q_r;
  assign ram_q    = ram_q_r;
  assign clearing = clearing_r;

endmodule
